FILE: sv/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler.
// Holds the per-task timing word type, phase, action and register codes,
// and time helpers. No dependencies.
package mlfq_pkg;

    localparam int TIME_W = 48;
    localparam int ACC_W  = 32;

    typedef struct packed {
        logic [TIME_W-1:0] mark;
        logic [TIME_W-1:0] pstart;
        logic [TIME_W-1:0] resume;
        logic [ACC_W-1:0]  acc;
        logic [ACC_W-1:0]  used;
    } task_word_t;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SCAN = 3'd1;
    localparam logic [2:0] PH_UPD  = 3'd2;
    localparam logic [2:0] PH_PICK = 3'd3;
    localparam logic [2:0] PH_RUN  = 3'd4;
    localparam logic [2:0] PH_FIX  = 3'd5;
    localparam logic [2:0] PH_EMIT = 3'd6;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_RESUME  = 2'd1;
    localparam logic [1:0] ACT_SUSPEND = 2'd2;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MAX_LEVEL = 2'd1;
    localparam logic [1:0] CFG_SLICE     = 2'd2;
    localparam logic [1:0] CFG_PERIOD    = 2'd3;

    function automatic logic [TIME_W-1:0] since48(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] t);
        return now - t;
    endfunction

    function automatic logic [ACC_W-1:0] sat32(input logic [ACC_W-1:0] a,
                                               input logic [TIME_W-1:0] d);
        logic [TIME_W:0] s;
        s = {{(TIME_W+1-ACC_W){1'b0}}, a} + {1'b0, d};
        return (|s[TIME_W:ACC_W]) ? '1 : s[ACC_W-1:0];
    endfunction

endpackage

FILE: sv/mlfq_accelerator_scheduler.sv
// Multilevel feedback queue scheduler for accelerator queues.
// Uses mlfq_pkg. Per-task timing words live in a one-port synchronous memory.
//
// Usage: a word is taken when start is high and busy is low. cmd 0 writes one
// slot of the slot table and completes at once (busy stays low). cmd 1 is a
// tick: busy rises and the block walks the slot table in six passes, each
// pass one slot (or device) at a time through a read-modify-write of the
// task memory: edge scan of every slot, accounting of each ready slot, pick
// over the ready slots, run for each device with a chosen task, cleanup of
// the slots and emit for every slot (on an idle tick emit ends at once).
// The busy time is set by the single memory port and the four-stage
// promote/demote step. Results come during emit, each for one cycle on
// result_valid; the receiver cannot stall. An idle tick gives one result
// with action none and last set. busy is low again once emit has passed
// the last slot, which can come after the cycle that shows the last result.
// Configuration is written on the cfg channel (cfg_ready is always high);
// the user must write it only while busy is low; the block does not
// enforce this. Reset clears the slot table, task flags and clock; the
// timing memory is written on a task's first sighting before any read.
module mlfq_accelerator_scheduler
    import mlfq_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int NUM_TASKS   = 16,
    parameter int NUM_DEVICES = 4,
    parameter int NUM_LEVELS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [3:0]  slot,
    input  logic [3:0]  task_id,
    input  logic [1:0]  device,
    input  logic        ready_req,
    input  logic        present,
    input  logic [19:0] elapsed_us,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic        result_valid,
    output logic [3:0]  out_slot,
    output logic [1:0]  action,
    output logic        last,
    output logic        rearm
);

    localparam int SW  = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam int TW  = NUM_TASKS > 1 ? $clog2(NUM_TASKS) : 1;
    localparam int DW  = NUM_DEVICES > 1 ? $clog2(NUM_DEVICES) : 1;
    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int CW  = $clog2(NUM_SLOTS + 1);
    localparam int NW  = CW + 4;
    localparam int PW  = ACC_W + NW;
    localparam int SLW = 20 + NUM_LEVELS;

    // configuration
    logic [23:0] thr_reg;
    logic [2:0]  max_level_reg;
    logic [19:0] slice_base_reg;
    logic [19:0] period_reg;

    // control
    logic [2:0]  phase_reg;
    logic [1:0]  sub_reg;
    logic [SW-1:0] s_reg;
    logic [DW-1:0] d_reg;
    logic [TIME_W-1:0] now_reg;

    logic          slot_live_reg  [NUM_SLOTS];
    logic [3:0]    slot_task_reg  [NUM_SLOTS];
    logic [1:0]    slot_dev_reg   [NUM_SLOTS];
    logic          slot_ready_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] mask_reg;

    logic          seen_reg    [NUM_TASKS];
    logic [LW-1:0] level_reg   [NUM_TASKS];
    logic          was_rdy_reg [NUM_TASKS];
    logic          running_reg [NUM_TASKS];
    logic          chosen_reg  [NUM_TASKS];

    logic [CW-1:0] cnt_reg [NUM_DEVICES][NUM_LEVELS];

    logic          has_best_reg  [NUM_DEVICES];
    logic [TW-1:0] best_task_reg [NUM_DEVICES];
    logic [LW-1:0] best_lvl_reg  [NUM_DEVICES];
    logic [ACC_W-1:0] best_acc_reg [NUM_DEVICES];

    logic       result_valid_reg;
    logic [3:0] out_slot_reg;
    logic [1:0] action_reg;
    logic       last_reg;
    logic       rearm_reg;

    // task memory
    task_word_t mem [NUM_TASKS];
    task_word_t q_reg;
    logic       mem_rd;
    logic       mem_we;
    logic [TW-1:0] mem_addr;
    task_word_t mem_wdata;

    // accounting pipeline
    task_word_t upd_reg;
    logic [TIME_W-1:0] el_reg;
    logic          el_gt_reg;
    logic          diff_big_reg;
    logic [ACC_W-1:0] diff_lo_reg;
    logic [CW-1:0] nn_reg;
    logic [PW-1:0] prod_reg;
    logic [ACC_W+3:0] p9_reg;
    logic          small_reg;

    // current slot view
    logic          cur_live;
    logic [3:0]    cur_task;
    logic [1:0]    cur_dev;
    logic          cur_ready;
    logic          usable;
    logic          ur;
    logic [TW-1:0] t_idx;
    logic [DW-1:0] d_idx;
    logic          last_slot;
    logic          last_dev;
    logic [LW-1:0] lvl_cur;
    logic          slot_done;
    logic          dev_done;
    logic [2:0]    seq_next;
    logic [SW-1:0] wr_idx;
    logic [NUM_SLOTS-1:0] mask_hi;

    // accounting step combinational
    logic [TIME_W-1:0] el_c;
    logic [TIME_W:0]   diff_c;
    task_word_t        sa_c;
    logic [NW-1:0]     nn10_c;
    logic              promote;
    logic [LW-1:0]     lvl_p;
    logic [LW-1:0]     cap;
    logic [SLW-1:0]    slice;
    logic              demote;
    logic [LW-1:0]     lvl_fin;
    logic              run_fin;
    task_word_t        upd_c;
    logic              pick_take;

    assign busy         = (phase_reg != PH_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign out_slot     = out_slot_reg;
    assign action       = action_reg;
    assign last         = last_reg;
    assign rearm        = rearm_reg;

    always_comb
    begin
        cur_live  = slot_live_reg[s_reg];
        cur_task  = slot_task_reg[s_reg];
        cur_dev   = slot_dev_reg[s_reg];
        cur_ready = slot_ready_reg[s_reg];
        usable    = cur_live && (32'(cur_task) < NUM_TASKS)
                    && (32'(cur_dev) < NUM_DEVICES);
        ur        = usable && cur_ready;
        t_idx     = TW'(cur_task);
        d_idx     = DW'(cur_dev);
        last_slot = (s_reg == SW'(NUM_SLOTS - 1));
        last_dev  = (d_reg == DW'(NUM_DEVICES - 1));
        lvl_cur   = level_reg[t_idx];
        wr_idx    = SW'(slot);
        mask_hi   = mask_reg >> s_reg;
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_SCAN: seq_next = PH_UPD;
            PH_UPD:  seq_next = PH_PICK;
            PH_PICK: seq_next = PH_RUN;
            PH_RUN:  seq_next = PH_FIX;
            PH_FIX:  seq_next = PH_EMIT;
            default: seq_next = PH_IDLE;
        endcase
        slot_done = 1'b0;
        dev_done  = 1'b0;
        unique case (phase_reg)
            PH_SCAN: slot_done = (sub_reg == 2'd1);
            PH_UPD:  slot_done = (sub_reg == 2'd0 && !ur) || (sub_reg == 2'd3);
            PH_PICK: slot_done = (sub_reg == 2'd0 && !ur) || (sub_reg == 2'd1);
            PH_FIX:  slot_done = (sub_reg == 2'd0 && !ur) || (sub_reg == 2'd1);
            PH_RUN:  dev_done  = (sub_reg == 2'd0 && !has_best_reg[d_reg])
                                 || (sub_reg == 2'd1);
            PH_EMIT: slot_done = 1'b1;
            default: slot_done = 1'b0;
        endcase
    end

    // accounting, promotion and demotion
    always_comb
    begin
        sa_c = q_reg;
        if (!running_reg[t_idx])
        begin
            sa_c.acc    = sat32(q_reg.acc, since48(now_reg, q_reg.pstart));
            sa_c.pstart = now_reg;
        end
        else
        begin
            sa_c.used   = sat32(q_reg.used, since48(now_reg, q_reg.resume));
            sa_c.resume = now_reg;
        end
        el_c   = since48(now_reg, q_reg.mark);
        diff_c = {1'b0, el_c} - (TIME_W+1)'(thr_reg);
        nn10_c = (NW'(nn_reg) << 3) + (NW'(nn_reg) << 1);

        cap = ({2'b00, max_level_reg} > 5'(NUM_LEVELS - 1)) ? LW'(NUM_LEVELS - 1)
                                                             : LW'(max_level_reg);
        if (nn_reg > CW'(1))
            promote = el_gt_reg && (diff_big_reg ||
                      ({{(64-PW){1'b0}}, prod_reg} > 64'(p9_reg)));
        else
            promote = small_reg;
        upd_c = upd_reg;
        lvl_p = lvl_cur;
        if (promote)
        begin
            if (lvl_cur != '0)
                lvl_p = lvl_cur - 1'b1;
            upd_c.mark = now_reg;
            upd_c.acc  = '0;
            upd_c.used = '0;
        end
        slice   = SLW'(slice_base_reg) << lvl_p;
        demote  = running_reg[t_idx] && (64'(upd_c.used) >= 64'(slice));
        lvl_fin = lvl_p;
        run_fin = running_reg[t_idx];
        if (demote)
        begin
            if (lvl_p < cap)
                lvl_fin = lvl_p + 1'b1;
            upd_c.mark   = now_reg;
            upd_c.used   = '0;
            upd_c.acc    = '0;
            upd_c.pstart = now_reg;
            run_fin      = 1'b0;
        end

        pick_take = !has_best_reg[d_idx] || (lvl_cur < best_lvl_reg[d_idx])
                    || (lvl_cur == best_lvl_reg[d_idx] && q_reg.acc > best_acc_reg[d_idx]);
    end

    // memory port control
    always_comb
    begin
        mem_rd    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = q_reg;
        mem_addr  = (phase_reg == PH_RUN) ? best_task_reg[d_reg] : t_idx;
        unique case (phase_reg)
            PH_SCAN:
            begin
                if (sub_reg == 2'd0)
                    mem_rd = usable && seen_reg[t_idx];
                else
                begin
                    mem_we = usable;
                    if (!seen_reg[t_idx])
                    begin
                        mem_wdata.mark   = now_reg;
                        mem_wdata.pstart = now_reg;
                        mem_wdata.resume = now_reg;
                        mem_wdata.acc    = '0;
                        mem_wdata.used   = '0;
                    end
                    else if (cur_ready && !was_rdy_reg[t_idx])
                        mem_wdata.pstart = now_reg;
                end
            end
            PH_UPD:
            begin
                mem_rd    = (sub_reg == 2'd0) && ur;
                mem_we    = (sub_reg == 2'd3);
                mem_wdata = upd_c;
            end
            PH_PICK:
                mem_rd = (sub_reg == 2'd0) && ur;
            PH_RUN:
            begin
                mem_rd = (sub_reg == 2'd0) && has_best_reg[d_reg];
                mem_we = (sub_reg == 2'd1);
                mem_wdata.resume = now_reg;
                if (!running_reg[best_task_reg[d_reg]])
                    mem_wdata.pstart = now_reg;
            end
            PH_FIX:
            begin
                mem_rd = (sub_reg == 2'd0) && ur;
                mem_we = (sub_reg == 2'd1) && !chosen_reg[t_idx] && running_reg[t_idx];
                mem_wdata.pstart = now_reg;
            end
            default:
                mem_rd = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_rd)
            q_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_UPD && sub_reg == 2'd0)
            nn_reg <= cnt_reg[d_idx][lvl_cur];
        if (phase_reg == PH_UPD && sub_reg == 2'd1)
        begin
            upd_reg      <= sa_c;
            el_reg       <= el_c;
            el_gt_reg    <= !diff_c[TIME_W] && (diff_c != '0);
            diff_big_reg <= |diff_c[TIME_W-1:ACC_W];
            diff_lo_reg  <= diff_c[ACC_W-1:0];
        end
        if (phase_reg == PH_UPD && sub_reg == 2'd2)
        begin
            prod_reg  <= PW'(diff_lo_reg) * PW'(nn10_c);
            p9_reg    <= ((ACC_W+4)'(upd_reg.acc) << 3) + (ACC_W+4)'(upd_reg.acc);
            small_reg <= {1'b0, el_reg} >
                         ((TIME_W+1)'(thr_reg) + (TIME_W+1)'(upd_reg.acc));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg          <= 24'd100000;
            max_level_reg    <= 3'd7;
            slice_base_reg   <= 20'd10000;
            period_reg       <= 20'd5000;
            phase_reg        <= PH_IDLE;
            sub_reg          <= '0;
            s_reg            <= '0;
            d_reg            <= '0;
            now_reg          <= '0;
            mask_reg         <= '0;
            result_valid_reg <= 1'b0;
            out_slot_reg     <= '0;
            action_reg       <= ACT_NONE;
            last_reg         <= 1'b0;
            rearm_reg        <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_live_reg[i]  <= 1'b0;
                slot_task_reg[i]  <= '0;
                slot_dev_reg[i]   <= '0;
                slot_ready_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                seen_reg[i]    <= 1'b0;
                level_reg[i]   <= '0;
                was_rdy_reg[i] <= 1'b0;
                running_reg[i] <= 1'b0;
                chosen_reg[i]  <= 1'b0;
            end
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                has_best_reg[i]  <= 1'b0;
                best_task_reg[i] <= '0;
                best_lvl_reg[i]  <= '0;
                best_acc_reg[i]  <= '0;
                for (int j = 0; j < NUM_LEVELS; j++)
                    cnt_reg[i][j] <= '0;
            end
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg        <= cfg_data;
                    CFG_MAX_LEVEL: max_level_reg  <= cfg_data[2:0];
                    CFG_SLICE:     slice_base_reg <= cfg_data[19:0];
                    CFG_PERIOD:    period_reg     <= cfg_data[19:0];
                endcase
            end

            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start && !cmd && (32'(slot) < NUM_SLOTS))
                    begin
                        slot_live_reg[wr_idx]  <= present;
                        slot_task_reg[wr_idx]  <= task_id;
                        slot_dev_reg[wr_idx]   <= device;
                        slot_ready_reg[wr_idx] <= ready_req;
                    end
                    if (start && cmd)
                    begin
                        now_reg   <= now_reg + TIME_W'(elapsed_us);
                        mask_reg  <= '0;
                        phase_reg <= PH_SCAN;
                        s_reg     <= '0;
                        d_reg     <= '0;
                        sub_reg   <= '0;
                        for (int i = 0; i < NUM_TASKS; i++)
                            chosen_reg[i] <= 1'b0;
                        for (int i = 0; i < NUM_DEVICES; i++)
                        begin
                            has_best_reg[i] <= 1'b0;
                            for (int j = 0; j < NUM_LEVELS; j++)
                                cnt_reg[i][j] <= '0;
                        end
                    end
                end
                PH_SCAN:
                begin
                    if (sub_reg == 2'd1 && usable)
                    begin
                        seen_reg[t_idx]    <= 1'b1;
                        was_rdy_reg[t_idx] <= cur_ready;
                        if (!seen_reg[t_idx])
                        begin
                            level_reg[t_idx]   <= '0;
                            running_reg[t_idx] <= 1'b0;
                        end
                        if (cur_ready)
                        begin
                            mask_reg[s_reg] <= 1'b1;
                            if (seen_reg[t_idx])
                                cnt_reg[d_idx][lvl_cur] <= cnt_reg[d_idx][lvl_cur] + 1'b1;
                            else
                                cnt_reg[d_idx][0] <= cnt_reg[d_idx][0] + 1'b1;
                        end
                    end
                end
                PH_UPD:
                begin
                    if (sub_reg == 2'd3)
                    begin
                        level_reg[t_idx]   <= lvl_fin;
                        running_reg[t_idx] <= run_fin;
                    end
                end
                PH_PICK:
                begin
                    if (sub_reg == 2'd1 && pick_take)
                    begin
                        has_best_reg[d_idx]  <= 1'b1;
                        best_task_reg[d_idx] <= t_idx;
                        best_lvl_reg[d_idx]  <= lvl_cur;
                        best_acc_reg[d_idx]  <= q_reg.acc;
                    end
                end
                PH_RUN:
                begin
                    if (sub_reg == 2'd1)
                    begin
                        running_reg[best_task_reg[d_reg]] <= 1'b1;
                        chosen_reg[best_task_reg[d_reg]]  <= 1'b1;
                    end
                end
                PH_FIX:
                begin
                    if (sub_reg == 2'd0 && usable && !cur_ready)
                        running_reg[t_idx] <= 1'b0;
                    if (sub_reg == 2'd1 && !chosen_reg[t_idx])
                        running_reg[t_idx] <= 1'b0;
                end
                PH_EMIT:
                begin
                    if (mask_reg == '0)
                    begin
                        result_valid_reg <= 1'b1;
                        out_slot_reg     <= '0;
                        action_reg       <= ACT_NONE;
                        last_reg         <= 1'b1;
                        rearm_reg        <= 1'b0;
                    end
                    else if (mask_reg[s_reg])
                    begin
                        result_valid_reg <= 1'b1;
                        out_slot_reg     <= 4'(s_reg);
                        action_reg       <= chosen_reg[t_idx] ? ACT_RESUME : ACT_SUSPEND;
                        last_reg         <= ((mask_hi >> 1) == '0);
                        rearm_reg        <= ((mask_hi >> 1) == '0);
                    end
                end
                default:
                    phase_reg <= PH_IDLE;
            endcase

            if (phase_reg != PH_IDLE)
            begin
                if (phase_reg == PH_RUN)
                begin
                    if (dev_done)
                    begin
                        sub_reg <= '0;
                        if (last_dev)
                        begin
                            d_reg     <= '0;
                            phase_reg <= seq_next;
                        end
                        else
                            d_reg <= d_reg + 1'b1;
                    end
                    else
                        sub_reg <= sub_reg + 1'b1;
                end
                else if (phase_reg == PH_EMIT && mask_reg == '0)
                begin
                    s_reg     <= '0;
                    phase_reg <= PH_IDLE;
                end
                else if (slot_done)
                begin
                    sub_reg <= '0;
                    if (last_slot)
                    begin
                        s_reg     <= '0;
                        phase_reg <= seq_next;
                    end
                    else
                        s_reg <= s_reg + 1'b1;
                end
                else
                    sub_reg <= sub_reg + 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result after last word of a tick");

    a_status_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cmd |=> !busy)
        else $error("status word made the block busy");

    a_none_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && action == ACT_NONE |-> last && !rearm)
        else $error("action none outside idle tick");

    a_rearm_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && rearm |-> last)
        else $error("rearm on non-last word");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(phase_reg) == PH_EMIT)
        else $error("result outside emit pass");
`endif

endmodule

FILE: bench/mlfq_accelerator_scheduler_test.sv
// Self-checking bench for mlfq_accelerator_scheduler: directed and random slot
// updates and ticks, predicted in-bench and compared result by result.
// Depends on mlfq_pkg and the scheduler RTL.
module mlfq_accelerator_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mlfq_pkg::*;

    localparam int NS = 16, NT = 16, ND = 4, NL = 8;
    localparam logic CMD_STATUS = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  slot;
        logic [3:0]  task_id;
        logic [1:0]  device;
        logic        ready_req;
        logic        present;
        logic [19:0] elapsed_us;
    } sched_word_t;

    typedef struct packed {
        logic [3:0] out_slot;
        logic [1:0] action;
        logic       last;
        logic       rearm;
    } action_word_t;

    logic clk = 0, rst_n = 0, start = 0, busy;
    logic cmd = 0, ready_req = 0, present = 0;
    logic [3:0] slot = 0, task_id = 0;
    logic [1:0] device = 0;
    logic [19:0] elapsed_us = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [1:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    logic result_valid, last, rearm;
    logic [3:0] out_slot;
    logic [1:0] action;

    mlfq_accelerator_scheduler dut (.*);

    initial forever #2 clk = ~clk;

    // predictor state
    logic [23:0] p_thr;
    logic [2:0]  p_maxlvl;
    logic [19:0] p_slice;
    logic [19:0] p_period;
    logic        s_live[NS], s_ready[NS];
    logic [3:0]  s_task[NS];
    logic [1:0]  s_dev[NS];
    logic [47:0] p_now;
    logic        t_seen[NT], t_wasr[NT], t_run[NT];
    logic [2:0]  t_lvl[NT];
    logic [47:0] t_mark[NT], t_pst[NT], t_res[NT];
    logic [31:0] t_acc[NT], t_used[NT];

    sched_word_t  pending_words[$];
    action_word_t expected_actions[$];
    int errors = 0;
    longint cycles = 0;
    bit stim_done = 0;
    bit took = 0;

    function automatic logic [31:0] acc_add(logic [31:0] a, logic [47:0] d);
        logic [48:0] s;
        s = {17'd0, a} + {1'b0, d};
        return (|s[48:32]) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void schedule_tick(sched_word_t w);
        int cnt[ND][NL];
        bit has_best[ND], chosen[NT], any_ready;
        int best[ND];
        int t, d, n;
        logic [2:0] cap;
        logic [47:0] el;
        logic [127:0] lhs, rhs, nn, slice;
        action_word_t r;
        cap = (p_maxlvl < NL - 1) ? p_maxlvl : 3'(NL - 1);
        any_ready = 0;
        n = 0;
        if (w.cmd == CMD_STATUS) begin
            s_live[w.slot] = w.present;
            s_task[w.slot] = w.task_id;
            s_dev[w.slot] = w.device;
            s_ready[w.slot] = w.ready_req;
            return;
        end
        p_now = p_now + 48'(w.elapsed_us);
        for (int s = 0; s < NS; s++) begin
            if (!s_live[s]) continue;
            t = s_task[s];
            if (!t_seen[t]) begin
                t_seen[t] = 1; t_lvl[t] = 0; t_wasr[t] = 0; t_run[t] = 0;
                t_mark[t] = p_now; t_pst[t] = p_now; t_res[t] = p_now;
                t_acc[t] = 0; t_used[t] = 0;
            end
            if (s_ready[s] && !t_wasr[t]) t_pst[t] = p_now;
            t_wasr[t] = s_ready[s];
        end
        for (int a = 0; a < ND; a++)
            for (int b = 0; b < NL; b++) cnt[a][b] = 0;
        for (int s = 0; s < NS; s++)
            if (s_live[s] && s_ready[s]) cnt[s_dev[s]][t_lvl[s_task[s]]]++;
        for (int s = 0; s < NS; s++) begin
            if (!s_live[s] || !s_ready[s]) continue;
            any_ready = 1;
            t = s_task[s];
            if (!t_run[t]) begin
                t_acc[t] = acc_add(t_acc[t], p_now - t_pst[t]);
                t_pst[t] = p_now;
            end else begin
                t_used[t] = acc_add(t_used[t], p_now - t_res[t]);
                t_res[t] = p_now;
            end
            nn = cnt[s_dev[s]][t_lvl[t]];
            el = p_now - t_mark[t];
            if (nn > 1) begin
                lhs = 10 * nn * el;
                rhs = 10 * nn * p_thr + 9 * 128'(t_acc[t]);
            end else begin
                lhs = el;
                rhs = 128'(p_thr) + t_acc[t];
            end
            if (lhs > rhs) begin
                if (t_lvl[t] > 0) t_lvl[t]--;
                t_mark[t] = p_now; t_acc[t] = 0; t_used[t] = 0;
            end
            slice = 128'(p_slice) << t_lvl[t];
            if (t_run[t] && t_used[t] >= slice) begin
                if (t_lvl[t] < cap) t_lvl[t]++;
                t_mark[t] = p_now; t_used[t] = 0; t_acc[t] = 0;
                t_run[t] = 0; t_pst[t] = p_now;
            end
        end
        for (int a = 0; a < ND; a++) begin has_best[a] = 0; best[a] = 0; end
        for (int a = 0; a < NT; a++) chosen[a] = 0;
        for (int s = 0; s < NS; s++) begin
            if (!s_live[s] || !s_ready[s]) continue;
            t = s_task[s]; d = s_dev[s];
            if (!has_best[d] || t_lvl[t] < t_lvl[best[d]]) begin
                has_best[d] = 1; best[d] = t;
            end else if (t_lvl[t] == t_lvl[best[d]] && t_acc[t] > t_acc[best[d]])
                best[d] = t;
        end
        for (d = 0; d < ND; d++) begin
            if (!has_best[d]) continue;
            t = best[d];
            if (!t_run[t]) begin t_run[t] = 1; t_pst[t] = p_now; end
            t_res[t] = p_now;
            chosen[t] = 1;
        end
        for (int s = 0; s < NS; s++) begin
            if (!s_live[s]) continue;
            t = s_task[s];
            if (!s_ready[s]) t_run[t] = 0;
            else if (!chosen[t] && t_run[t]) begin
                t_run[t] = 0; t_pst[t] = p_now;
            end
        end
        for (int s = 0; s < NS; s++) begin
            if (!s_live[s] || !s_ready[s]) continue;
            r.out_slot = 4'(s);
            r.action = chosen[s_task[s]] ? ACT_RESUME : ACT_SUSPEND;
            r.last = 0; r.rearm = 0;
            expected_actions.push_back(r);
            n++;
        end
        if (n == 0) begin
            r.out_slot = 0; r.action = ACT_NONE; r.last = 1; r.rearm = 0;
            expected_actions.push_back(r);
        end else begin
            r = expected_actions.pop_back();
            r.last = 1; r.rearm = any_ready;
            expected_actions.push_back(r);
        end
    endfunction

    // acceptance seen at the rising edge
    always @(posedge clk)
        took <= rst_n && start && !busy;

    // driver
    int gap = 0;
    always @(negedge clk) begin
        sched_word_t w;
        if (rst_n) begin
            if (took) begin
                // word accepted at the previous rising edge
                schedule_tick(pending_words.pop_front());
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                gap--;
                start <= 0;
            end else if (pending_words.size() > 0) begin
                w = pending_words[0];
                start <= 1;
                {cmd, slot, task_id, device, ready_req, present, elapsed_us} <= w;
            end else
                start <= 0;
        end
    end

    // monitor
    always @(posedge clk) begin
        action_word_t exp_w;
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (rst_n && result_valid) begin
            if (expected_actions.size() == 0) begin
                $error("unexpected result slot %0d", out_slot);
                errors++;
            end else begin
                exp_w = expected_actions.pop_front();
                if (out_slot !== exp_w.out_slot) begin
                    $error("out_slot exp %0d got %0d", exp_w.out_slot, out_slot); errors++;
                end
                if (action !== exp_w.action) begin
                    $error("action exp %0d got %0d", exp_w.action, action); errors++;
                end
                if (last !== exp_w.last) begin
                    $error("last exp %0d got %0d", exp_w.last, last); errors++;
                end
                if (rearm !== exp_w.rearm) begin
                    $error("rearm exp %0d got %0d", exp_w.rearm, rearm); errors++;
                end
            end
        end
    end

    function automatic sched_word_t status_word(int s, int t, int d, bit r, bit p);
        sched_word_t w;
        w = '0;
        w.cmd = CMD_STATUS; w.slot = 4'(s); w.task_id = 4'(t); w.device = 2'(d);
        w.ready_req = r; w.present = p; w.elapsed_us = 20'($urandom);
        return w;
    endfunction

    function automatic sched_word_t tick_word(logic [19:0] e);
        sched_word_t w;
        w = sched_word_t'($urandom);
        w.cmd = CMD_TICK; w.elapsed_us = e;
        return w;
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || expected_actions.size() > 0 || busy || start)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        case (idx)
            CFG_THRESHOLD: p_thr = val;
            CFG_MAX_LEVEL: p_maxlvl = val[2:0];
            CFG_SLICE:     p_slice = val[19:0];
            CFG_PERIOD:    p_period = val[19:0];
            default: ;
        endcase
    endtask

    function automatic logic [19:0] rand_elapsed();
        case ($urandom_range(0, 5))
            0: return 20'hFFFFF;
            1: return 0;
            2: return 20'($urandom_range(0, 200));
            default: return 20'($urandom_range(0, 40000));
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0)
                pending_words.push_back(tick_word(rand_elapsed()));
            else
                pending_words.push_back(status_word($urandom_range(0, 15),
                    $urandom_range(0, 7), $urandom, $urandom_range(0, 3) != 0,
                    $urandom_range(0, 5) != 0));
            if (i == count / 2)
                while (pending_words.size() > 0 || expected_actions.size() > 0)
                    @(posedge clk);
        end
        drain();
    endtask

    initial begin
        p_thr = 100000; p_maxlvl = 7; p_slice = 10000; p_period = 5000;
        p_now = 0;
        for (int i = 0; i < NS; i++) begin
            s_live[i] = 0; s_ready[i] = 0; s_task[i] = 0; s_dev[i] = 0;
        end
        for (int i = 0; i < NT; i++) begin
            t_seen[i] = 0; t_wasr[i] = 0; t_run[i] = 0; t_lvl[i] = 0;
            t_mark[i] = 0; t_pst[i] = 0; t_res[i] = 0; t_acc[i] = 0; t_used[i] = 0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: idle tick, extremes, shared task, ties, slice exhaustion
        pending_words.push_back(tick_word(20'hFFFFF));
        pending_words.push_back(status_word(0, 0, 0, 1, 1));
        pending_words.push_back(status_word(15, 15, 3, 1, 1));
        pending_words.push_back(status_word(5, 0, 1, 1, 1));
        pending_words.push_back(status_word(6, 3, 0, 1, 1));
        pending_words.push_back(status_word(7, 4, 0, 0, 1));
        pending_words.push_back(tick_word(0));
        pending_words.push_back(tick_word(20'd5000));
        pending_words.push_back(tick_word(20'hFFFFF));
        pending_words.push_back(tick_word(20'hFFFFF));
        pending_words.push_back(status_word(15, 15, 3, 0, 0));
        pending_words.push_back(tick_word(20'd1));
        drain();
        write_reg(CFG_THRESHOLD, 24'd0);
        write_reg(CFG_MAX_LEVEL, 24'd0);
        write_reg(CFG_SLICE, 24'd1);
        write_reg(CFG_PERIOD, 24'd1);
        for (int i = 0; i < 6; i++) pending_words.push_back(tick_word(20'($urandom_range(0, 9))));
        drain();
        write_reg(CFG_THRESHOLD, 24'hFFFFFF);
        write_reg(CFG_MAX_LEVEL, 24'd7);
        write_reg(CFG_SLICE, 24'hFFFFF);
        write_reg(CFG_PERIOD, 24'hFFFFF);
        for (int i = 0; i < 5; i++) pending_words.push_back(tick_word(20'hFFFFF));
        drain();

        // random phases across settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_THRESHOLD, ph[0] ? 24'($urandom_range(0, 60000)) : 24'($urandom));
            write_reg(CFG_MAX_LEVEL, 24'($urandom_range(0, 7)));
            write_reg(CFG_SLICE, ph == 3 ? 24'd1 : 24'($urandom_range(1, 30000)));
            write_reg(CFG_PERIOD, 24'($urandom_range(1, 20'hFFFFF)));
            random_phase(60);
        end
        stim_done = 1;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: sim.f
sv/mlfq_pkg.sv
sv/mlfq_accelerator_scheduler.sv
bench/mlfq_accelerator_scheduler_test.sv
